FILE: rtl/montgomery_modular_exponentiation_core_macros.svh
// Assertion macros for the Montgomery exponentiation core.
// No dependencies; included by the files that check their own logic.
`ifndef MONTGOMERY_MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MONTGOMERY_MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MME_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MME_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/mme_pkg.sv
// Shared types and constants of the Montgomery exponentiation core.
// No dependencies; used by the controller, the datapath and the top level.
package mme_pkg;

  localparam int unsigned OperandBits = 17;
  localparam int unsigned CountBits   = 16;
  localparam int unsigned CntBits     = $clog2(OperandBits + 1);
  localparam int unsigned CfgIdxBits  = 2;

  typedef logic [OperandBits-1:0] operand_t;
  typedef logic [CountBits-1:0]   count_t;
  typedef logic [CntBits-1:0]     cnt_t;
  typedef logic [CfgIdxBits-1:0]  cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CfgModulus  = 2'd0;
  localparam cfg_idx_t CfgRSquared = 2'd1;
  localparam cfg_idx_t CfgRepeat   = 2'd2;

  // reset values of the configuration registers
  localparam operand_t ModulusReset  = 17'd77837;
  localparam operand_t RSquaredReset = 17'd75729;
  localparam count_t   RepeatReset   = 16'd17;

  // controller -> datapath commands
  typedef struct packed {
    logic load_in;  // capture a new request, clear accumulators
    logic reduce;   // one MSB-first reduction step on y and R^2
    logic reload;   // previous product becomes the scanned operand
    logic mul;      // one radix-2 Montgomery step
    logic use_y;    // multiplicand: y when set, R^2 otherwise
  } dp_cmd_t;

endpackage

FILE: rtl/mme_datapath.sv
// Datapath: operand registers, bit-serial modular reduction and Montgomery step.
// Depends on mme_pkg; driven by mme_controller commands.
module mme_datapath (
  input  logic              clk_i,
  input  mme_pkg::dp_cmd_t  cmd_i,
  input  mme_pkg::operand_t modulus_i,
  input  mme_pkg::operand_t r_squared_i,
  input  mme_pkg::operand_t base_i,
  input  mme_pkg::operand_t mult_i,
  output mme_pkg::operand_t result_o
);

  localparam int unsigned W = mme_pkg::OperandBits;

  mme_pkg::operand_t n;
  mme_pkg::operand_t a_q, a_d;
  mme_pkg::operand_t acc_q, acc_d;
  mme_pkg::operand_t y_q, y_d, rr_q, rr_d;
  mme_pkg::operand_t ys_q, ys_d, rs_q, rs_d;
  mme_pkg::operand_t mcand, t_add;
  logic [W:0]        t_half;

  // (a + b) mod n for a, b below n
  function automatic mme_pkg::operand_t mod_add(input mme_pkg::operand_t a,
                                                input mme_pkg::operand_t b,
                                                input mme_pkg::operand_t m);
    logic [W:0] s;
    logic [W:0] r;
    s = {1'b0, a} + {1'b0, b};
    r = (s >= {1'b0, m}) ? (s - {1'b0, m}) : s;
    return r[W-1:0];
  endfunction

  assign n     = modulus_i | mme_pkg::operand_t'(1);
  assign mcand = cmd_i.use_y ? y_q : rr_q;
  assign t_add = a_q[0] ? mod_add(acc_q, mcand, n) : acc_q;
  // (t + n) / 2 when t is odd, t / 2 otherwise
  assign t_half = t_add[0] ? ({1'b0, t_add} + {1'b0, n}) : {1'b0, t_add};

  always_comb begin
    a_d   = a_q;
    acc_d = acc_q;
    y_d   = y_q;
    rr_d  = rr_q;
    ys_d  = ys_q;
    rs_d  = rs_q;
    if (cmd_i.load_in) begin
      a_d   = base_i;
      acc_d = '0;
      y_d   = '0;
      rr_d  = '0;
      ys_d  = mult_i;
      rs_d  = r_squared_i;
    end else if (cmd_i.reduce) begin
      y_d  = mod_add(mod_add(y_q, y_q, n), mme_pkg::operand_t'(ys_q[W-1]), n);
      rr_d = mod_add(mod_add(rr_q, rr_q, n), mme_pkg::operand_t'(rs_q[W-1]), n);
      ys_d = {ys_q[W-2:0], 1'b0};
      rs_d = {rs_q[W-2:0], 1'b0};
    end else if (cmd_i.reload) begin
      a_d   = acc_q;
      acc_d = '0;
    end else if (cmd_i.mul) begin
      acc_d = t_half[W:1];
      a_d   = {1'b0, a_q[W-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    acc_q <= acc_d;
    y_q   <= y_d;
    rr_q  <= rr_d;
    ys_q  <= ys_d;
    rs_q  <= rs_d;
  end

  assign result_o = acc_q;

endmodule

FILE: rtl/mme_controller.sv
// Sequencer: reduction pass, then the chain of Montgomery products.
// Depends on mme_pkg; issues dp_cmd_t to mme_datapath.
module mme_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mme_pkg::count_t   repeat_count_i,
  input  logic              out_free_i,
  output logic              out_load_o,
  output mme_pkg::dp_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRed  = 3'd1;
  localparam logic [2:0] StMrr  = 3'd2;
  localparam logic [2:0] StMy   = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  localparam mme_pkg::cnt_t RedLast = mme_pkg::cnt_t'(mme_pkg::OperandBits - 1);
  localparam mme_pkg::cnt_t MulLast = mme_pkg::cnt_t'(mme_pkg::OperandBits);

  logic [2:0]      state_q, state_d;
  mme_pkg::cnt_t   cnt_q, cnt_d;
  mme_pkg::count_t k_q, k_d;
  logic            first_q, first_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    first_d    = first_q;
    cmd_o      = '0;
    out_load_o = 1'b0;
    in_stall_o = (state_q != StIdle);
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StRed;
          cnt_d         = '0;
          k_d           = '0;
          first_d       = 1'b1;
        end
      end
      StRed: begin
        cmd_o.reduce = 1'b1;
        if (cnt_q == RedLast) begin
          state_d = StMrr;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StMrr, StMy: begin
        cmd_o.use_y = (state_q == StMy);
        if (cnt_q == '0) begin
          // setup slot: first product scans x, later ones the last product
          cmd_o.reload = !first_q;
          first_d      = 1'b0;
        end else begin
          cmd_o.mul = 1'b1;
        end
        if (cnt_q == MulLast) begin
          cnt_d = '0;
          if (state_q == StMrr) begin
            state_d = StMy;
          end else if (k_q == repeat_count_i) begin
            state_d = StDone;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = StMrr;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StDone: begin
        out_load_o = out_free_i;
        if (out_free_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      k_q     <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      first_q <= first_d;
    end
  end

endmodule

FILE: rtl/montgomery_modular_exponentiation_core.sv
// Montgomery modular exponentiation core: result = x * y^(repeat_count+1) mod n,
// using 17-bit radix-2 bit-serial Montgomery products (R = 2^17). One request
// is processed at a time. After acceptance the core reduces y and the R^2
// residue modulo n bit by bit, MSB first, then runs 2*(repeat_count+1)
// Montgomery products, each a setup slot followed by one Montgomery step per
// operand bit, then hands the result over to the output register once that
// register is free. All products share the single Montgomery step unit in
// the datapath. A finished result sits in the output register while the
// next request is already accepted.
// An even modulus is used as modulus|1. Configuration writes are always
// ready; write only while the core is idle. Depends on mme_pkg, the macro
// header, mme_controller and mme_datapath.
`include "montgomery_modular_exponentiation_core_macros.svh"

module montgomery_modular_exponentiation_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mme_pkg::operand_t base_value_i,
  input  mme_pkg::operand_t multiplier_value_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mme_pkg::operand_t result_value_o,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  mme_pkg::cfg_idx_t cfg_index_i,
  input  mme_pkg::operand_t cfg_data_i
);

  mme_pkg::operand_t modulus_q, r_squared_q;
  mme_pkg::count_t   repeat_q;
  mme_pkg::operand_t result_q;
  logic              out_valid_q;

  mme_pkg::dp_cmd_t  cmd;
  mme_pkg::operand_t dp_result;
  logic              out_free, out_load;

  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= mme_pkg::ModulusReset;
      r_squared_q <= mme_pkg::RSquaredReset;
      repeat_q    <= mme_pkg::RepeatReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mme_pkg::CfgModulus:  modulus_q   <= cfg_data_i;
        mme_pkg::CfgRSquared: r_squared_q <= cfg_data_i;
        mme_pkg::CfgRepeat:   repeat_q    <= cfg_data_i[mme_pkg::CountBits-1:0];
        default: ;
      endcase
    end
  end

  // output register: free when empty or drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_q <= dp_result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;

  mme_controller u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .repeat_count_i (repeat_q),
    .out_free_i     (out_free),
    .out_load_o     (out_load),
    .cmd_o          (cmd)
  );

  mme_datapath u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .modulus_i   (modulus_q),
    .r_squared_i (r_squared_q),
    .base_i      (base_value_i),
    .mult_i      (multiplier_value_i),
    .result_o    (dp_result)
  );

  // accepted request keeps the core busy for the next cycle
  `MME_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // never overwrite a result that has not been taken
  `MME_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, out_load, !out_valid_q || !out_stall_i)
  // a delivered product is fully reduced
  `MME_ASSERT_NOW(a_result_reduced, clk_i, rst_ni, out_load, dp_result < (modulus_q | 17'd1))

endmodule

FILE: tb/montgomery_modular_exponentiation_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Montgomery exponentiation core. Directed and random
// requests are checked against an in-bench predictor of x * y^(count+1) mod n.
// Depends on mme_pkg and montgomery_modular_exponentiation_core.
module montgomery_modular_exponentiation_core_tb;
  import mme_pkg::*;

  localparam int unsigned CycleLimit    = 12_000_000;
  localparam int unsigned MaxIdle       = 18;
  localparam int unsigned RandomPhases  = 12;
  localparam int unsigned PhaseRequests = 66;
  localparam int unsigned HoldOffCycles = 2500;

  // one bit wider than an operand, holds a modular sum before reduction
  typedef logic [OperandBits:0] sum_t;

  logic     clk_i              = 1'b0;
  logic     rst_ni             = 1'b0;
  logic     in_valid_i         = 1'b0;
  logic     in_stall_o;
  operand_t base_value_i       = '0;
  operand_t multiplier_value_i = '0;
  logic     out_valid_o;
  logic     out_stall_i        = 1'b0;
  operand_t result_value_o;
  logic     cfg_valid_i        = 1'b0;
  logic     cfg_ready_o;
  cfg_idx_t cfg_index_i        = CfgModulus;
  operand_t cfg_data_i         = '0;

  // shadow copies of the configuration registers
  operand_t modulus_reg  = ModulusReset;
  operand_t rsquared_reg = RSquaredReset;
  count_t   repeat_reg   = RepeatReset;

  operand_t    expected_powers[$];
  int          error_count     = 0;
  int          requests_sent   = 0;
  int          results_checked = 0;
  int unsigned cycle_count     = 0;
  bit          src_steady      = 1'b0;  // sender offers back to back
  bit          sink_steady     = 1'b0;  // receiver never stalls
  int          hold_off_cycles = 0;     // one long receiver stall, picked up by the sink

  montgomery_modular_exponentiation_core uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .base_value_i       (base_value_i),
    .multiplier_value_i (multiplier_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_value_o     (result_value_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------------------
  // Predictor: same arithmetic as the hardware, one bit per loop step.
  // ---------------------------------------------------------------------------

  // (a + b) mod n for a, b < n
  function automatic sum_t modular_sum(sum_t a, sum_t b, sum_t n);
    sum_t gap;
    gap = n - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

  // v mod n, MSB first: double and add the next bit
  function automatic sum_t reduce_mod(operand_t v, sum_t n);
    sum_t r;
    int   i;
    r = '0;
    for (i = OperandBits - 1; i >= 0; i--) begin
      r = modular_sum(r, r, n);
      r = modular_sum(r, (n == 1) ? sum_t'(0) : sum_t'(v[i]), n);
    end
    return r;
  endfunction

  // a * b / 2^OperandBits mod n; b < n, n odd, partial sums kept below n
  function automatic sum_t montgomery_product(operand_t a, sum_t b, sum_t n);
    sum_t t;
    int   i;
    t = '0;
    for (i = 0; i < OperandBits; i++) begin
      if (a[i]) t = modular_sum(t, b, n);
      if (t[0]) t = (t >> 1) + (n >> 1) + 1'b1;
      else t = t >> 1;
    end
    return t;
  endfunction

  // x * y^(count+1) mod n under the current shadow configuration
  function automatic operand_t predict_power(operand_t x, operand_t y);
    sum_t        n;
    sum_t        y_red;
    sum_t        rr_red;
    sum_t        acc;
    int unsigned k;
    n      = {1'b0, modulus_reg | operand_t'(1)};  // even modulus acts as modulus|1
    y_red  = reduce_mod(y, n);
    rr_red = reduce_mod(rsquared_reg, n);
    acc    = montgomery_product(x, rr_red, n);
    acc    = montgomery_product(operand_t'(acc), y_red, n);
    for (k = 0; k < repeat_reg; k++) begin
      acc = montgomery_product(operand_t'(acc), rr_red, n);
      acc = montgomery_product(operand_t'(acc), y_red, n);
    end
    return operand_t'(acc);
  endfunction

  // correct R^2 residue, 2^(2*OperandBits) mod (n|1)
  function automatic operand_t r_squared_for(operand_t n);
    longint unsigned m;
    m = n | operand_t'(1);
    return operand_t'((64'd1 << (2 * OperandBits)) % m);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one request after a random gap; returns at the edge that accepts it.
  // Valid is left high so the next call can keep it up without a glitch.
  task automatic send_request(input operand_t x, input operand_t y);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, MaxIdle);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    base_value_i       <= x;
    multiplier_value_i <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_powers.push_back(predict_power(x, y));
    requests_sent++;
  endtask

  // Drop valid and wait until every accepted request has come back.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_t idx, input operand_t data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgModulus:  modulus_reg  = data;
      CfgRSquared: rsquared_reg = data;
      CfgRepeat:   repeat_reg   = data[CountBits-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Registers change only once the core has drained.
  task automatic set_config(input operand_t n, input operand_t rsq, input operand_t count_word);
    wait_for_results();
    write_register(CfgModulus, n);
    write_register(CfgRSquared, rsq);
    write_register(CfgRepeat, count_word);
  endtask

  // Result side: random stall per result, or one long hold-off when requested.
  initial begin : result_sink
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles != 0) begin
        gap = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        gap = sink_steady ? 0 : $urandom_range(0, MaxIdle);
      end
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!(out_valid_o === 1'b1 && !out_stall_i)) @(posedge clk_i);
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    operand_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (expected_powers.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected, expected none, actual %0d",
                 $time, result_value_o);
      end else begin
        want = expected_powers.pop_front();
        results_checked++;
        if (result_value_o !== want) begin
          error_count++;
          $display("%0t: result_value mismatch, expected %0d, actual %0d",
                   $time, want, result_value_o);
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("%0t: timeout after %0d cycles, %0d results outstanding",
             $time, cycle_count, expected_powers.size());
    $display("montgomery_modular_exponentiation_core_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration (count 17, exponent 19 when x == y): operand extremes.
  task automatic test_reset_values();
    send_request(17'd0, 17'd0);
    send_request(17'd131071, 17'd131071);  // both above the modulus
    send_request(17'd1, 17'd1);
    send_request(17'd12345, 17'd12345);    // encryption of one message word
    send_request(17'd77836, 17'd2);
    send_request(17'd5, 17'd77837);        // y equal to the modulus reduces to zero
    send_request(17'd77837, 17'd131071);
  endtask

  task automatic test_special_moduli();
    // even modulus is used with bit 0 forced on
    set_config(17'd77836, RSquaredReset, 17'd0);
    send_request(17'd1234, 17'd5678);
    send_request(17'd131071, 17'd77836);
    // zero modulus behaves as one, result always zero
    set_config(17'd0, 17'd12345, 17'd0);
    send_request(17'd999, 17'd888);
    // smallest odd modulus above one and the largest odd modulus
    set_config(17'd3, r_squared_for(17'd3), 17'd2);
    send_request(17'd2, 17'd2);
    send_request(17'd131071, 17'd131071);
    set_config(17'd131071, r_squared_for(17'd131071), 17'd1);
    send_request(17'd131070, 17'd131069);
    send_request(17'd65536, 17'd131071);
  endtask

  task automatic test_residue_cases();
    // residue above the modulus gets reduced first
    set_config(ModulusReset, 17'd131071, 17'd1);
    send_request(17'd4242, 17'd999);
    // residue that is simply wrong: chain still follows the configured value
    set_config(ModulusReset, 17'd12345, 17'd3);
    send_request(17'd31337, 17'd27182);
    send_request(17'd0, 17'd131071);
    set_config(ModulusReset, 17'd0, 17'd0);
    send_request(17'd100, 17'd200);
  endtask

  // Count 0 gives a single product by y; the all-ones write masks to 65535.
  task automatic test_count_extremes();
    set_config(ModulusReset, RSquaredReset, 17'd0);
    send_request(17'd12345, 17'd12345);
    set_config(ModulusReset, RSquaredReset, 17'h1FFFF);
    send_request(17'd54321, 17'd54321);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering, so
  // the output register fills and the core stalls its input.
  task automatic test_output_hold_off();
    operand_t n;
    int       i;
    n = operand_t'($urandom) | operand_t'(3);
    set_config(n, r_squared_for(n), 17'd1);
    src_steady      = 1'b1;
    sink_steady     = 1'b0;
    hold_off_cycles = HoldOffCycles;
    for (i = 0; i < 24; i++) begin
      send_request(operand_t'($urandom), operand_t'($urandom));
    end
    src_steady = 1'b0;
    wait_for_results();
  endtask

  // Random configurations, mostly small counts; most operands below the modulus.
  task automatic test_random_phases();
    operand_t    n;
    operand_t    rsq;
    operand_t    count_word;
    operand_t    x;
    operand_t    y;
    int unsigned top;
    int          p;
    int          i;
    for (p = 0; p < RandomPhases; p++) begin
      case ($urandom_range(0, 9))
        0:       n = 17'd3;
        1:       n = 17'd131071;
        2:       n = operand_t'($urandom) & ~operand_t'(1);
        3:       n = operand_t'($urandom_range(0, 1));
        default: n = operand_t'($urandom) | operand_t'(1);
      endcase
      rsq = ($urandom_range(0, 4) == 0) ? operand_t'($urandom) : r_squared_for(n);
      count_word = ($urandom_range(0, 3) == 0) ? operand_t'($urandom_range(4, 20))
                                               : operand_t'($urandom_range(0, 3));
      count_word[OperandBits-1] = 1'($urandom_range(0, 1));  // ignored upper data bit
      set_config(n, rsq, count_word);
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      top = (n | operand_t'(1)) - 1;
      for (i = 0; i < PhaseRequests; i++) begin
        if ($urandom_range(0, 39) == 0) wait_for_results();
        case ($urandom_range(0, 9))
          0, 1: begin
            x = operand_t'($urandom);
            y = operand_t'($urandom);
          end
          2, 3: begin
            x = operand_t'($urandom_range(0, top));
            y = x;  // message word, x == y
          end
          default: begin
            x = operand_t'($urandom_range(0, top));
            y = operand_t'($urandom_range(0, top));
          end
        endcase
        send_request(x, y);
      end
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin : main
    int settle;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_special_moduli();
    test_residue_cases();
    test_count_extremes();
    test_output_hold_off();
    test_random_phases();

    wait_for_results();
    // let a stray extra result show up before closing
    settle = 18 + 36 * (int'(repeat_reg) + 1);
    if (settle > 4000) settle = 4000;
    repeat (settle) @(posedge clk_i);
    if (expected_powers.size() != 0) begin
      error_count++;
      $display("%0t: results left over, expected 0, actual %0d",
               $time, expected_powers.size());
    end

    $display("covered %0d requests and %0d checked results over %0d cycles,",
             requests_sent, results_checked, cycle_count);
    $display("odd, even, zero and extreme moduli, wrong residues, counts 0 to 65535");
    if (error_count == 0) begin
      $display("montgomery_modular_exponentiation_core_tb: done, clean");
    end else begin
      $display("montgomery_modular_exponentiation_core_tb: done, errors");
    end
    $finish;
  end

endmodule
